>>> rtl/core/kls_pkg.sv
// Shared types and constants of the keypad scanner with long-press detection.
package kls_pkg;

  // Fixed field widths.
  localparam int unsigned ColW    = 4;
  localparam int unsigned DriveW  = 4;
  localparam int unsigned KeyIdxW = 2;
  localparam int unsigned TickW   = 10;

  // Tick counter saturation value.
  localparam logic [TickW-1:0] TickMax = '1;

  // Reset values of the threshold registers.
  localparam logic [TickW-1:0] ShortMinRst = 10'd3;
  localparam logic [TickW-1:0] LongMinRst  = 10'd100;

  // Default keypad geometry.
  localparam int unsigned DefRows    = 4;
  localparam int unsigned DefColumns = 4;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgShortMin = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongMin  = 2'd1;

  // One result word.
  typedef struct packed {
    logic [DriveW-1:0]  row_drive;
    logic               key_valid;
    logic [KeyIdxW-1:0] key_row;
    logic [KeyIdxW-1:0] key_column;
    logic               long_press;
  } res_t;

endpackage

>>> rtl/core/kls_in_stage.sv
// Input register that holds one column sample word until the core takes it.
module kls_in_stage
  import kls_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ColW-1:0] cols_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic [ColW-1:0] cols_o
);

  logic            valid_q, valid_d;
  logic [ColW-1:0] cols_q;

  // A new word may enter when the stage is empty or drains this cycle.
  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Sample payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cols_q <= cols_i;
    end
  end

  assign valid_o = valid_q;
  assign cols_o  = cols_q;

endmodule

>>> rtl/core/kls_scan_core.sv
// Scan state, threshold registers and the per-tick update and classification.
module kls_scan_core
  import kls_pkg::*;
#(
  parameter int unsigned ROWS    = DefRows,
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  input  logic               step_i,
  input  logic [ColW-1:0]    cols_i,
  output res_t               res_o
);

  localparam int unsigned RowW    = $clog2(ROWS);
  localparam int unsigned NumCols = (COLUMNS < ColW) ? COLUMNS : ColW;

  logic [TickW-1:0]   short_min_q, long_min_q;
  logic [RowW-1:0]    scan_row_q, scan_row_d;
  logic               holding_q, holding_d;
  logic [RowW-1:0]    held_row_q, held_row_d;
  logic [KeyIdxW-1:0] held_col_q, held_col_d;
  logic [TickW-1:0]   ticks_q, ticks_d;

  logic               found;
  logic [KeyIdxW-1:0] found_col;
  logic [RowW-1:0]    drive_row;
  logic               key_low;
  logic               is_short, is_long;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= ShortMinRst;
      long_min_q  <= LongMinRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgShortMin: short_min_q <= cfg_data_i;
        CfgLongMin:  long_min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Lowest low column wins: search from the top down so the last hit is the lowest.
  always_comb begin
    found     = 1'b0;
    found_col = '0;
    for (int c = NumCols - 1; c >= 0; c--) begin
      if (!cols_i[c]) begin
        found     = 1'b1;
        found_col = KeyIdxW'(c);
      end
    end
  end

  assign drive_row = holding_q ? held_row_q : scan_row_q;
  assign key_low   = !cols_i[held_col_q];
  assign is_short  = (ticks_q > short_min_q) && (ticks_q < long_min_q);
  assign is_long   = ticks_q > long_min_q;

  // Next state and result for one tick.
  always_comb begin
    scan_row_d = scan_row_q;
    holding_d  = holding_q;
    held_row_d = held_row_q;
    held_col_d = held_col_q;
    ticks_d    = ticks_q;

    res_o = '0;
    for (int b = 0; b < DriveW; b++) begin
      res_o.row_drive[b] = (b < ROWS) && (b != int'(drive_row));
    end

    if (!holding_q) begin
      if (found) begin
        holding_d  = 1'b1;
        held_row_d = scan_row_q;
        held_col_d = found_col;
        ticks_d    = '0;
      end else if (scan_row_q == RowW'(ROWS - 1)) begin
        scan_row_d = '0;
      end else begin
        scan_row_d = scan_row_q + 1'b1;
      end
    end else if (key_low) begin
      if (ticks_q != TickMax) begin
        ticks_d = ticks_q + 1'b1;
      end
    end else begin
      // Release: classify the press and restart the scan at row 0.
      if (is_short || is_long) begin
        res_o.key_valid  = 1'b1;
        res_o.long_press = !is_short;
        res_o.key_row    = KeyIdxW'(held_row_q);
        res_o.key_column = held_col_q;
      end
      holding_d  = 1'b0;
      scan_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      holding_q  <= 1'b0;
      held_row_q <= '0;
      held_col_q <= '0;
      ticks_q    <= '0;
    end else if (step_i) begin
      scan_row_q <= scan_row_d;
      holding_q  <= holding_d;
      held_row_q <= held_row_d;
      held_col_q <= held_col_d;
      ticks_q    <= ticks_d;
    end
  end

endmodule

>>> rtl/core/kls_out_stage.sv
// Result register that holds one result word until the consumer takes it.
module kls_out_stage
  import kls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic can_push_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // Room for a new word when empty or when the held word leaves this cycle.
  assign can_push_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/keypad_scan_long_press.sv
// Top level of the matrix keypad scanner with short and long press detection.
// Each input word is one scan tick carrying the active-low column sample of the
// row that was driven; each accepted word yields exactly one result word with the
// row drive pattern for that tick and, on a key release classified as short or long,
// the key's row and column and whether the press was long. The block takes one word
// per clock cycle while the result side does not stall it; each word passes through
// the input register and then the result register, with the state update between
// them. Backpressure on the result side stalls the input only once the result
// register is full and not being drained. The threshold registers (index 0: short
// minimum, index 1: long minimum) are always ready and should be written while idle.
module keypad_scan_long_press
  import kls_pkg::*;
#(
  parameter int unsigned ROWS    = DefRows,
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ColW-1:0]    column_lines_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DriveW-1:0]  row_drive_o,
  output logic               key_valid_o,
  output logic [KeyIdxW-1:0] key_row_o,
  output logic [KeyIdxW-1:0] key_column_o,
  output logic               long_press_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i
);

  logic            stage_valid;
  logic [ColW-1:0] stage_cols;
  logic            can_push;
  logic            step;
  res_t            core_res;
  res_t            out_res;

  // A tick is processed when a sample is held and the result register has room.
  assign step        = stage_valid && can_push;
  assign cfg_ready_o = 1'b1;

  kls_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cols_i     (column_lines_i),
    .pop_i      (step),
    .valid_o    (stage_valid),
    .cols_o     (stage_cols)
  );

  kls_scan_core #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_scan_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .cols_i      (stage_cols),
    .res_o       (core_res)
  );

  kls_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .res_i       (core_res),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Result word onto the output ports.
  assign row_drive_o  = out_res.row_drive;
  assign key_valid_o  = out_res.key_valid;
  assign key_row_o    = out_res.key_row;
  assign key_column_o = out_res.key_column;
  assign long_press_o = out_res.long_press;

endmodule
